FILE: hdl/tet_pkg.sv
// Shared definitions for the type-encoding tokenizer: kind and mode codes,
// character constants, the token and batch types, and the character classifier.
// No dependencies.
`default_nettype none

package tet_pkg;

  // String length limit and field widths.
  localparam int MAX_STRING_LENGTH = 4096;
  localparam int POS_W = 13;
  localparam int KIND_W = 5;
  localparam int NUM_W = 2;

  // Result queue geometry.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // Scan modes.
  localparam logic [2:0] MODE_NORMAL   = 3'd0;
  localparam logic [2:0] MODE_AFTER_AT = 3'd1;
  localparam logic [2:0] MODE_IN_QUOTE = 3'd2;
  localparam logic [2:0] MODE_UNTIL_EQ = 3'd3;
  localparam logic [2:0] MODE_DIGITS   = 3'd4;

  // Token kinds.
  localparam logic [KIND_W-1:0] K_INVALID     = 5'd0;
  localparam logic [KIND_W-1:0] K_VOID        = 5'd1;
  localparam logic [KIND_W-1:0] K_BASIC       = 5'd2;
  localparam logic [KIND_W-1:0] K_CSTRING     = 5'd3;
  localparam logic [KIND_W-1:0] K_OBJECT      = 5'd4;
  localparam logic [KIND_W-1:0] K_CLASS       = 5'd5;
  localparam logic [KIND_W-1:0] K_SELECTOR    = 5'd6;
  localparam logic [KIND_W-1:0] K_ARRAY_START = 5'd7;
  localparam logic [KIND_W-1:0] K_ARRAY_END   = 5'd8;
  localparam logic [KIND_W-1:0] K_STRUCT_START = 5'd9;
  localparam logic [KIND_W-1:0] K_STRUCT_END  = 5'd10;
  localparam logic [KIND_W-1:0] K_UNION_START = 5'd11;
  localparam logic [KIND_W-1:0] K_UNION_END   = 5'd12;
  localparam logic [KIND_W-1:0] K_BITFIELD    = 5'd13;
  localparam logic [KIND_W-1:0] K_POINTER     = 5'd14;
  localparam logic [KIND_W-1:0] K_UNKNOWN     = 5'd15;
  localparam logic [KIND_W-1:0] K_END         = 5'd16;

  // Characters with a role in the grammar.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_B_LOW  = 8'h62;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // One result item.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  offset;
    logic [POS_W-1:0]  length;
    logic              unterminated;
    logic              last;
  } tet_token_t;

  // All results caused by one request, packed to the low slots.
  typedef struct packed {
    logic [NUM_W-1:0]   num;
    tet_token_t [2:0]   tok;
  } tet_batch_t;

  // Kind of a character that always forms a one-byte token.
  function automatic logic [KIND_W-1:0] simple_kind(input logic [7:0] b);
    logic [KIND_W-1:0] k;
    unique case (b)
      8'h76: k = K_VOID;                          // v
      8'h63, 8'h69, 8'h73, 8'h6C, 8'h71,
      8'h43, 8'h49, 8'h53, 8'h4C, 8'h51,
      8'h66, 8'h64, 8'h42: k = K_BASIC;           // c i s l q C I S L Q f d B
      8'h2A: k = K_CSTRING;                       // *
      8'h23: k = K_CLASS;                         // #
      8'h3A: k = K_SELECTOR;                      // :
      8'h5D: k = K_ARRAY_END;                     // ]
      8'h7D: k = K_STRUCT_END;                    // }
      8'h29: k = K_UNION_END;                     // )
      8'h5E: k = K_POINTER;                       // ^
      8'h3F: k = K_UNKNOWN;                       // ?
      default: k = K_INVALID;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/tet_lexer.sv
// Scan state and per-byte token generation for the type-encoding tokenizer.
// Depends on tet_pkg.
`default_nettype none

module tet_lexer
  import tet_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] byte_in,
  input  wire logic       end_of_string,
  output tet_batch_t      batch
);

  // Scan state.
  logic [2:0]        mode, mode_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [POS_W-1:0]  tstart, tstart_next;
  logic [KIND_W-1:0] pkind, pkind_next;
  logic              finished, finished_next;

  // Candidate results: pending token, this byte's token, end token.
  tet_token_t [2:0]  cand;
  logic [2:0]        cand_vld;
  logic              forced;
  logic              absorbed;
  logic              ended;
  logic [7:0]        term;
  logic [POS_W-1:0]  len_incl;
  logic [POS_W-1:0]  len_excl;
  logic [NUM_W-1:0]  num;
  tet_token_t [2:0]  packed_tok;

  assign forced   = end_of_string || (pos >= POS_W'(MAX_STRING_LENGTH - 1));
  assign len_incl = pos + POS_W'(1) - tstart;
  assign len_excl = pos - tstart;
  assign term     = (mode == MODE_IN_QUOTE) ? CH_QUOTE : CH_EQUAL;

  // Token generation for the current byte.
  always_comb begin
    cand     = '0;
    cand_vld = '0;
    absorbed = 1'b0;
    ended    = 1'b0;
    mode_next   = mode;
    tstart_next = tstart;
    pkind_next  = pkind;
    cand[0].kind   = pkind;
    cand[0].offset = tstart;

    // Close or extend the pending token.
    unique case (mode)
      MODE_AFTER_AT: begin
        if (byte_in == CH_QUOTE) begin
          absorbed  = 1'b1;
          mode_next = MODE_IN_QUOTE;
          if (forced) begin
            cand_vld[0] = 1'b1;
            cand[0].length = len_incl;
            cand[0].unterminated = 1'b1;
            mode_next = MODE_NORMAL;
          end
        end else begin
          cand_vld[0] = 1'b1;
          cand[0].length = POS_W'(1);
          mode_next = MODE_NORMAL;
        end
      end
      MODE_IN_QUOTE, MODE_UNTIL_EQ: begin
        if (byte_in == CH_NUL) begin
          cand_vld[0] = 1'b1;
          cand[0].length = len_excl;
          cand[0].unterminated = 1'b1;
          mode_next = MODE_NORMAL;
        end else begin
          absorbed = 1'b1;
          if (byte_in == term) begin
            cand_vld[0] = 1'b1;
            cand[0].length = len_incl;
            mode_next = MODE_NORMAL;
          end else if (forced) begin
            cand_vld[0] = 1'b1;
            cand[0].length = len_incl;
            cand[0].unterminated = 1'b1;
            mode_next = MODE_NORMAL;
          end
        end
      end
      MODE_DIGITS: begin
        if (byte_in >= CH_ZERO && byte_in <= CH_NINE) begin
          absorbed = 1'b1;
          if (forced) begin
            cand_vld[0] = 1'b1;
            cand[0].length = len_incl;
            mode_next = MODE_NORMAL;
          end
        end else begin
          cand_vld[0] = 1'b1;
          cand[0].length = len_excl;
          mode_next = MODE_NORMAL;
        end
      end
      default: mode_next = MODE_NORMAL;
    endcase

    // Tokenize the byte itself when the pending token did not take it.
    cand[1].offset = pos;
    cand[1].length = POS_W'(1);
    if (!absorbed) begin
      priority if (byte_in == CH_NUL) begin
        cand_vld[1] = 1'b1;
        cand[1].kind = K_END;
        ended = 1'b1;
      end else if (byte_in == CH_AT || byte_in == CH_LBRACK || byte_in == CH_B_LOW ||
                   byte_in == CH_LBRACE || byte_in == CH_LPAREN) begin
        tstart_next = pos;
        priority if (byte_in == CH_AT) begin
          pkind_next = K_OBJECT;
          mode_next  = MODE_AFTER_AT;
        end else if (byte_in == CH_LBRACK) begin
          pkind_next = K_ARRAY_START;
          mode_next  = MODE_DIGITS;
        end else if (byte_in == CH_B_LOW) begin
          pkind_next = K_BITFIELD;
          mode_next  = MODE_DIGITS;
        end else if (byte_in == CH_LBRACE) begin
          pkind_next = K_STRUCT_START;
          mode_next  = MODE_UNTIL_EQ;
        end else begin
          pkind_next = K_UNION_START;
          mode_next  = MODE_UNTIL_EQ;
        end
        if (forced) begin
          cand_vld[1] = 1'b1;
          cand[1].kind = pkind_next;
          cand[1].unterminated = (mode_next == MODE_UNTIL_EQ);
          mode_next = MODE_NORMAL;
        end
      end else begin
        cand_vld[1] = 1'b1;
        cand[1].kind = simple_kind(byte_in);
      end
    end

    // End token after the last byte of the string or at the length cap.
    cand[2].kind   = K_END;
    cand[2].offset = pos + POS_W'(1);
    cand[2].length = POS_W'(1);
    if (!ended && forced) begin
      cand_vld[2] = 1'b1;
      ended = 1'b1;
    end
  end

  // Pack valid candidates to the low slots and mark the final one.
  always_comb begin
    packed_tok = '0;
    num = '0;
    if (!finished) begin
      for (int i = 0; i < 3; i++) begin
        if (cand_vld[i]) begin
          packed_tok[num] = cand[i];
          num = num + NUM_W'(1);
        end
      end
    end
    if (num != '0) begin
      packed_tok[num - NUM_W'(1)].last = 1'b1;
    end
    batch.num = num;
    batch.tok = packed_tok;
  end

  logic [2:0]        mode_upd;
  logic [POS_W-1:0]  pos_upd;
  logic [POS_W-1:0]  tstart_upd;
  logic [KIND_W-1:0] pkind_upd;

  // State update on each accepted request.
  always_comb begin
    mode_upd      = mode;
    pos_upd       = pos;
    tstart_upd    = tstart;
    pkind_upd     = pkind;
    finished_next = finished;
    if (finished) begin
      if (end_of_string) begin
        mode_upd = MODE_NORMAL;
        pos_upd = '0;
        tstart_upd = '0;
        pkind_upd = '0;
        finished_next = 1'b0;
      end
    end else if (ended) begin
      mode_upd = MODE_NORMAL;
      if (end_of_string) begin
        pos_upd = '0;
        tstart_upd = '0;
        pkind_upd = '0;
      end else begin
        finished_next = 1'b1;
      end
    end else begin
      mode_upd   = mode_next;
      pos_upd    = pos + POS_W'(1);
      tstart_upd = tstart_next;
      pkind_upd  = pkind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_NORMAL;
      pos      <= '0;
      tstart   <= '0;
      pkind    <= '0;
      finished <= 1'b0;
    end else if (accept) begin
      mode     <= mode_upd;
      pos      <= pos_upd;
      tstart   <= tstart_upd;
      pkind    <= pkind_upd;
      finished <= finished_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/type_encoding_tokenizer.sv
// Type-encoding tokenizer: one byte per request, up to three tokens per byte.
// A token enters the result queue when its byte is taken and is offered from its head.
// Throughput: one byte per cycle while each byte yields at most one token and the
// output is ready; more tokens from one byte use the single output port in turn.
// The four-entry result queue accepts a byte only while it has room for three.
// Reset (rst, synchronous) clears the scan state and empties the result queue.
`default_nettype none

module type_encoding_tokenizer
  import tet_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        byte_in,
  input  wire logic              end_of_string,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [KIND_W-1:0]      token_kind,
  output logic [POS_W-1:0]       token_offset,
  output logic [POS_W-1:0]       token_length,
  output logic                   unterminated,
  output logic                   last_of_run
);

  logic         in_fire;
  logic         out_fire;
  tet_batch_t   batch;

  // Result queue.
  tet_token_t                 queue [Q_DEPTH];
  logic [Q_PTR_W-1:0]         wptr, rptr;
  logic [Q_CNT_W-1:0]         count, count_next;
  logic [Q_CNT_W-1:0]         num_in;
  tet_token_t                 head;

  assign in_ready  = (count <= Q_CNT_W'(Q_DEPTH - 3));
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign out_fire  = out_valid && out_ready;
  assign num_in    = in_fire ? Q_CNT_W'(batch.num) : '0;

  // Lexer state and token generation.
  tet_lexer u_lexer (
    .clk           (clk),
    .rst           (rst),
    .accept        (in_fire),
    .byte_in       (byte_in),
    .end_of_string (end_of_string),
    .batch         (batch)
  );

  // Write the new tokens behind the queue tail.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (in_fire && (NUM_W'(i) < batch.num)) begin
        queue[wptr + Q_PTR_W'(i)] <= batch.tok[i];
      end
    end
  end

  // Pointer and occupancy bookkeeping.
  assign count_next = count + num_in - (out_fire ? Q_CNT_W'(1) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + num_in[Q_PTR_W-1:0];
      if (out_fire) begin
        rptr <= rptr + Q_PTR_W'(1);
      end
      count <= count_next;
    end
  end

  // Head of the queue drives the output fields.
  assign head         = queue[rptr];
  assign token_kind   = head.kind;
  assign token_offset = head.offset;
  assign token_length = head.length;
  assign unterminated = head.unterminated;
  assign last_of_run  = head.last;

  // The queue never holds more than its depth.
  assert property (@(posedge clk) disable iff (rst) count <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue overflow");

  // Occupancy follows the tokens written and taken.
  assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> count == $past(count) + $past(num_in) - ($past(out_fire) ? 3'd1 : 3'd0))
    else $error("result queue count mismatch");

  // A byte is taken only when the queue has room for a full batch.
  assert property (@(posedge clk) disable iff (rst)
    in_fire |-> (count + Q_CNT_W'(batch.num) <= Q_CNT_W'(Q_DEPTH)))
    else $error("batch written into a queue without room");

  // The queue is empty right after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

`default_nettype wire

FILE: dv/type_encoding_tokenizer_test.sv
// Self-checking testbench for the type-encoding tokenizer: directed and random byte
// streams, a scoreboard fed by a scan predictor, random idling on both channels.
// Depends on tet_pkg and type_encoding_tokenizer.
`default_nettype none

module type_encoding_tokenizer_test;
  import tet_pkg::*;

  localparam int RANDOM_ITEMS = 370;
  localparam int CYCLE_LIMIT = 500000;
  localparam int N_DIRECTED = 25;

  // One row of the directed table; kind and offset hold a typed-in token when typed is set.
  typedef struct packed {
    logic [7:0]        chr;
    logic              eos;
    logic              typed;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  offset;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] byte_in = 8'h00;
  logic end_of_string = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [KIND_W-1:0] token_kind;
  logic [POS_W-1:0] token_offset;
  logic [POS_W-1:0] token_length;
  logic unterminated;
  logic last_of_run;

  // Scan state of the predictor.
  logic [2:0]        lex_mode;
  logic [POS_W-1:0]  lex_pos;
  logic [POS_W-1:0]  lex_start;
  logic [KIND_W-1:0] lex_kind;
  logic              lex_done;

  // Tokens produced by the byte just predicted.
  tet_token_t run_tok [3];
  int run_n;

  tet_token_t awaited_tokens [$];
  int error_count = 0;
  int tokens_seen = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_cycles = 0;
  string simple_chars = "vcislqCISLQfdB*#:]})^?";

  // Directed stream: a full string with every deferred token kind, a zero byte
  // while a '(' is open, dropped bytes, a three-token last byte, a lone zero.
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{"v", 1'b0, 1'b1, K_VOID, 13'd0},
    '{"i", 1'b0, 1'b1, K_BASIC, 13'd1},
    '{8'hFF, 1'b0, 1'b1, K_INVALID, 13'd2},
    '{CH_AT, 1'b0, 1'b0, K_INVALID, 13'd0},
    '{CH_QUOTE, 1'b0, 1'b0, K_INVALID, 13'd0},
    '{"N", 1'b0, 1'b0, K_INVALID, 13'd0},
    '{CH_QUOTE, 1'b0, 1'b0, K_INVALID, 13'd0},
    '{CH_AT, 1'b0, 1'b0, K_INVALID, 13'd0},
    '{":", 1'b0, 1'b0, K_INVALID, 13'd0},
    '{CH_LBRACK, 1'b0, 1'b0, K_INVALID, 13'd0},
    '{"1", 1'b0, 1'b0, K_INVALID, 13'd0},
    '{"2", 1'b0, 1'b0, K_INVALID, 13'd0},
    '{"]", 1'b0, 1'b0, K_INVALID, 13'd0},
    '{CH_LBRACE, 1'b0, 1'b0, K_INVALID, 13'd0},
    '{"x", 1'b0, 1'b0, K_INVALID, 13'd0},
    '{CH_EQUAL, 1'b0, 1'b0, K_INVALID, 13'd0},
    '{CH_B_LOW, 1'b0, 1'b0, K_INVALID, 13'd0},
    '{"5", 1'b0, 1'b0, K_INVALID, 13'd0},
    '{CH_LPAREN, 1'b0, 1'b0, K_INVALID, 13'd0},
    '{CH_NUL, 1'b0, 1'b0, K_INVALID, 13'd0},
    '{"x", 1'b0, 1'b0, K_INVALID, 13'd0},
    '{"x", 1'b1, 1'b0, K_INVALID, 13'd0},
    '{CH_LBRACK, 1'b0, 1'b0, K_INVALID, 13'd0},
    '{"v", 1'b1, 1'b0, K_INVALID, 13'd0},
    '{CH_NUL, 1'b1, 1'b1, K_END, 13'd0}
  };

  type_encoding_tokenizer i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .byte_in(byte_in),
    .end_of_string(end_of_string),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .token_kind(token_kind),
    .token_offset(token_offset),
    .token_length(token_length),
    .unterminated(unterminated),
    .last_of_run(last_of_run)
  );

  always #1 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Kind of a character that stands alone as a one-byte token.
  function automatic logic [KIND_W-1:0] char_kind(input logic [7:0] b);
    case (b)
      "v": return K_VOID;
      "c", "i", "s", "l", "q", "C", "I", "S", "L", "Q", "f", "d", "B": return K_BASIC;
      "*": return K_CSTRING;
      "#": return K_CLASS;
      ":": return K_SELECTOR;
      "]": return K_ARRAY_END;
      "}": return K_STRUCT_END;
      ")": return K_UNION_END;
      "^": return K_POINTER;
      "?": return K_UNKNOWN;
      default: return K_INVALID;
    endcase
  endfunction

  function automatic void restart_string();
    lex_mode = MODE_NORMAL;
    lex_pos = '0;
    lex_start = '0;
    lex_kind = K_INVALID;
    lex_done = 1'b0;
  endfunction

  function automatic void add_token(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] off,
                                    input logic [POS_W-1:0] len, input logic unt);
    run_tok[run_n] = '{kind: k, offset: off, length: len, unterminated: unt, last: 1'b0};
    run_n++;
  endfunction

  // Advances the scan state by one byte and leaves its tokens in run_tok.
  function automatic void scan_byte(input logic [7:0] b, input logic eos);
    logic [POS_W-1:0] p;
    logic forced;
    logic absorbed;
    logic ended;
    logic [7:0] term;
    p = lex_pos;
    forced = eos || (int'(p) + 1 >= MAX_STRING_LENGTH);
    absorbed = 1'b0;
    ended = 1'b0;
    run_n = 0;
    // After the end token, bytes are dropped up to the end of the string.
    if (lex_done) begin
      if (eos) restart_string();
      return;
    end
    // Close or extend a pending token.
    case (lex_mode)
      MODE_AFTER_AT: begin
        if (b == CH_QUOTE) begin
          absorbed = 1'b1;
          lex_mode = MODE_IN_QUOTE;
          if (forced) begin
            add_token(lex_kind, lex_start, p + POS_W'(1) - lex_start, 1'b1);
            lex_mode = MODE_NORMAL;
          end
        end else begin
          add_token(lex_kind, lex_start, POS_W'(1), 1'b0);
          lex_mode = MODE_NORMAL;
        end
      end
      MODE_IN_QUOTE, MODE_UNTIL_EQ: begin
        term = (lex_mode == MODE_IN_QUOTE) ? CH_QUOTE : CH_EQUAL;
        if (b == CH_NUL) begin
          add_token(lex_kind, lex_start, p - lex_start, 1'b1);
          lex_mode = MODE_NORMAL;
        end else begin
          absorbed = 1'b1;
          if (b == term) begin
            add_token(lex_kind, lex_start, p + POS_W'(1) - lex_start, 1'b0);
            lex_mode = MODE_NORMAL;
          end else if (forced) begin
            add_token(lex_kind, lex_start, p + POS_W'(1) - lex_start, 1'b1);
            lex_mode = MODE_NORMAL;
          end
        end
      end
      MODE_DIGITS: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          absorbed = 1'b1;
          if (forced) begin
            add_token(lex_kind, lex_start, p + POS_W'(1) - lex_start, 1'b0);
            lex_mode = MODE_NORMAL;
          end
        end else begin
          add_token(lex_kind, lex_start, p - lex_start, 1'b0);
          lex_mode = MODE_NORMAL;
        end
      end
      default: lex_mode = MODE_NORMAL;
    endcase
    // Tokenize the byte itself.
    if (!absorbed) begin
      if (b == CH_NUL) begin
        add_token(K_END, p, POS_W'(1), 1'b0);
        ended = 1'b1;
      end else if (b == CH_AT || b == CH_LBRACK || b == CH_B_LOW || b == CH_LBRACE ||
                   b == CH_LPAREN) begin
        lex_start = p;
        if (b == CH_AT) begin
          lex_kind = K_OBJECT;
          lex_mode = MODE_AFTER_AT;
        end else if (b == CH_LBRACK || b == CH_B_LOW) begin
          lex_kind = (b == CH_LBRACK) ? K_ARRAY_START : K_BITFIELD;
          lex_mode = MODE_DIGITS;
        end else begin
          lex_kind = (b == CH_LBRACE) ? K_STRUCT_START : K_UNION_START;
          lex_mode = MODE_UNTIL_EQ;
        end
        if (forced) begin
          add_token(lex_kind, p, POS_W'(1), lex_mode == MODE_UNTIL_EQ);
          lex_mode = MODE_NORMAL;
        end
      end else begin
        add_token(char_kind(b), p, POS_W'(1), 1'b0);
      end
    end
    // The last byte of a string, or the length cap, closes it.
    if (!ended && forced) begin
      add_token(K_END, p + POS_W'(1), POS_W'(1), 1'b0);
      ended = 1'b1;
    end
    if (ended) begin
      if (eos) begin
        restart_string();
      end else begin
        lex_mode = MODE_NORMAL;
        lex_done = 1'b1;
      end
    end else begin
      lex_pos = p + POS_W'(1);
    end
    if (run_n > 0) run_tok[run_n-1].last = 1'b1;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    $display("ERROR: %s", msg);
  endtask

  task automatic compare_field(input string field, input int got, input int want);
    if (got != want)
      flag_error($sformatf("token %0d: %s is %0d, expected %0d", tokens_seen, field, got, want));
  endtask

  // Checks one accepted token against the oldest expectation.
  task automatic check_token();
    tet_token_t want;
    if (awaited_tokens.size() == 0) begin
      flag_error($sformatf("token %0d: kind %0d at offset %0d arrived with none expected",
                           tokens_seen, token_kind, token_offset));
    end else begin
      want = awaited_tokens.pop_front();
      compare_field("kind", int'(token_kind), int'(want.kind));
      compare_field("offset", int'(token_offset), int'(want.offset));
      compare_field("length", int'(token_length), int'(want.length));
      compare_field("unterminated", int'(unterminated), int'(want.unterminated));
      compare_field("last_of_run", int'(last_of_run), int'(want.last));
    end
    tokens_seen++;
  endtask

  // Token side: check what is taken, then pick the next ready.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) check_token();
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one request, waits for it to be taken, and records its tokens. A typed
  // token, where given, replaces the prediction as the expectation.
  task automatic send_request(input logic [7:0] chr, input logic eos,
                              input logic use_typed = 1'b0,
                              input logic [KIND_W-1:0] typed_kind = K_INVALID,
                              input logic [POS_W-1:0] typed_off = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in <= chr;
    end_of_string <= eos;
    do @(posedge clk); while (!in_ready);
    if (!lex_done) items_sent++;
    scan_byte(chr, eos);
    if (use_typed) begin
      awaited_tokens.push_back('{kind: typed_kind, offset: typed_off, length: 13'd1,
                                 unterminated: 1'b0, last: 1'b1});
    end else begin
      for (int i = 0; i < run_n; i++) awaited_tokens.push_back(run_tok[i]);
    end
  endtask

  function automatic logic [7:0] name_char();
    if ($urandom_range(3) == 0) return 8'($urandom_range(1, 255));
    return 8'("a" + $urandom_range(25));
  endfunction

  // Sends one string built from random constructs, some of them left open, then
  // ends it on its last byte, with a zero, or with a zero and dropped bytes.
  task automatic send_string(input int n_parts);
    logic [7:0] txt [$];
    int sel;
    int n;
    for (int i = 0; i < n_parts; i++) begin
      sel = $urandom_range(99);
      if (sel < 35) begin
        txt.push_back(simple_chars[$urandom_range(simple_chars.len() - 1)]);
      end else if (sel < 47) begin
        txt.push_back(CH_AT);
        if ($urandom_range(3) != 0) begin
          txt.push_back(CH_QUOTE);
          n = $urandom_range(5);
          for (int k = 0; k < n; k++) txt.push_back(name_char());
          if ($urandom_range(4) != 0) txt.push_back(CH_QUOTE);
        end
      end else if (sel < 62) begin
        txt.push_back($urandom_range(1) ? CH_LBRACK : CH_B_LOW);
        n = $urandom_range(3);
        for (int k = 0; k < n; k++) txt.push_back(8'(CH_ZERO + $urandom_range(9)));
      end else if (sel < 80) begin
        txt.push_back($urandom_range(1) ? CH_LBRACE : CH_LPAREN);
        n = $urandom_range(5);
        for (int k = 0; k < n; k++) txt.push_back(name_char());
        if ($urandom_range(4) != 0) txt.push_back(CH_EQUAL);
      end else begin
        txt.push_back(8'($urandom_range(1, 255)));
      end
    end
    sel = $urandom_range(99);
    for (int i = 0; i < txt.size() - 1; i++) send_request(txt[i], 1'b0);
    if (sel < 60) begin
      send_request(txt[txt.size() - 1], 1'b1);
    end else begin
      send_request(txt[txt.size() - 1], 1'b0);
      send_request(CH_NUL, sel < 80);
      if (sel >= 80) begin
        n = $urandom_range(3);
        for (int k = 0; k < n; k++) send_request(8'($urandom_range(255)), 1'b0);
        send_request(8'($urandom_range(255)), 1'b1);
      end
    end
  endtask

  // Stimulus: directed table, then three random phases with different idling.
  initial begin
    int target;
    restart_string();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 36;
          recv_idle_pct = 85;
        end
        1: begin
          send_idle_pct = 85;
          recv_idle_pct = 36;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // Long receiver stall while requests keep coming, so the input backs up.
          hold_off_cycles = 80;
        end
      endcase
      if (phase == 0) begin
        for (int r = 0; r < N_DIRECTED; r++)
          send_request(directed_rows[r].chr, directed_rows[r].eos, directed_rows[r].typed,
                       directed_rows[r].kind, directed_rows[r].offset);
        target = items_sent;
      end
      target = target + RANDOM_ITEMS / 3;
      while (items_sent < target) send_string($urandom_range(1, 8));
      // Sender pauses until every expected token has come back.
      in_valid <= 1'b0;
      do @(posedge clk); while (awaited_tokens.size() != 0);
    end
    repeat (20) @(posedge clk);
    if (error_count == 0 && awaited_tokens.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
hdl/tet_pkg.sv
hdl/tet_lexer.sv
hdl/type_encoding_tokenizer.sv
dv/type_encoding_tokenizer_test.sv
